/* hdl/nfsa_pkg.sv */
// Shared types, constants and helpers for the next-fit slot allocator.
package nfsa_pkg;

   localparam logic [6:0] POOL_CAPACITY   = 7'd64;
   localparam logic [6:0] RESET_POOL_SIZE = 7'd32;

   localparam logic [1:0] ACT_ALLOC_ONE  = 2'd0;
   localparam logic [1:0] ACT_ALLOC_MANY = 2'd1;
   localparam logic [1:0] ACT_RELEASE    = 2'd2;

   typedef enum logic [1:0] {
      CMD_SCAN,
      CMD_RELEASE,
      CMD_FAIL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         single;
      logic [6:0]   target;
      logic [5:0]   slot;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GROW
   } eng_state_type;

   function automatic logic [6:0] cap_size(input logic [6:0] v);
      cap_size = (v > POOL_CAPACITY) ? POOL_CAPACITY : v;
   endfunction

endpackage

/* hdl/nfsa_front.sv */
// Front end: accepts requests and decodes them into allocator commands.
module nfsa_front (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,  // [6:0] count, [12:7] slot, [15:13] zero
   input  logic [1:0]                 req_tuser,  // [1:0] action
   input  nfsa_pkg::queue_status_type q_status,
   output logic                       q_push,
   output nfsa_pkg::cmd_type          q_cmd
);
   import nfsa_pkg::*;

   logic [6:0] count;
   logic [5:0] slot;

   assign count      = req_tdata[6:0];
   assign slot       = req_tdata[12:7];
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && !q_status.full;

   always_comb begin
      q_cmd.kind   = CMD_FAIL;
      q_cmd.single = 1'b0;
      q_cmd.target = 7'd1;
      q_cmd.slot   = 6'd0;
      unique case (req_tuser)
         ACT_ALLOC_ONE: begin
            q_cmd.kind   = CMD_SCAN;
            q_cmd.single = 1'b1;
         end
         ACT_ALLOC_MANY: begin
            if (count != 7'd0) begin
               q_cmd.kind   = CMD_SCAN;
               q_cmd.target = cap_size(count);
            end
         end
         ACT_RELEASE: begin
            q_cmd.kind = CMD_RELEASE;
            q_cmd.slot = slot;
         end
         default: begin
            q_cmd.kind = CMD_FAIL;
         end
      endcase
   end

endmodule

/* hdl/nfsa_queue.sv */
// Two-entry command queue between the front end and the allocation engine.
module nfsa_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nfsa_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output nfsa_pkg::queue_status_type status,
   output nfsa_pkg::cmd_type          head_cmd
);
   import nfsa_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign status.valid = (cnt_ff != 2'd0);
   assign status.full  = (cnt_ff == 2'd2);
   assign head_cmd     = entries_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers inconsistent with count");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (status.full && !do_pop) |=> (cnt_ff == 2'd2))
      else $error("queue count changed while full");
`endif

endmodule

/* hdl/nfsa_engine.sv */
// Allocation engine: used flags, next-fit scan, pool growth and result register.
module nfsa_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [6:0]                 csr_wr_data,
   input  nfsa_pkg::queue_status_type q_status,
   input  nfsa_pkg::cmd_type          q_cmd,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,  // [5:0] granted_slot, [7:6] zero
   output logic                       rsp_tuser,  // [0] granted
   output logic                       rsp_tlast
);
   import nfsa_pkg::*;

   eng_state_type             state_ff, state_in;
   logic [POOL_CAPACITY-1:0]  used_ff, used_in;
   logic [6:0]                next_index_ff, next_index_in;
   logic [6:0]                pool_size_ff, pool_size_in;
   logic [6:0]                cur_ff, cur_in;
   logic                      pass_ff, pass_in;
   logic [6:0]                n_ff, n_in;
   logic [6:0]                target_ff, target_in;
   logic                      single_ff, single_in;

   logic                      out_valid_ff, out_valid_in;
   logic [5:0]                out_slot_ff, out_slot_in;
   logic                      out_ok_ff, out_ok_in;
   logic                      out_last_ff, out_last_in;

   logic                      out_free;
   logic [6:0]                scan_hi;
   logic                      in_range;
   logic                      slot_free;
   logic                      final_grant;
   logic                      release_ok;
   logic                      can_grow;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign scan_hi     = pass_ff ? next_index_ff : pool_size_ff;
   assign in_range    = cur_ff < scan_hi;
   assign slot_free   = !used_ff[cur_ff[5:0]];
   assign final_grant = (n_ff + 7'd1) == target_ff;
   assign release_ok  = ({1'b0, q_cmd.slot} < pool_size_ff) && used_ff[q_cmd.slot];
   assign can_grow    = pool_size_ff < POOL_CAPACITY;

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = {2'b00, out_slot_ff};
   assign rsp_tuser   = out_ok_ff;
   assign rsp_tlast   = out_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.valid && out_free && q_cmd.kind == CMD_SCAN) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (in_range) begin
                  if (slot_free && final_grant) begin
                     state_in = ST_IDLE;
                  end
               end else if (pass_ff) begin
                  state_in = ST_GROW;
               end
            end
         end
         ST_GROW: begin
            if (out_free && final_grant) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and results
   always_comb begin
      used_in       = used_ff;
      next_index_in = next_index_ff;
      pool_size_in  = pool_size_ff;
      cur_in        = cur_ff;
      pass_in       = pass_ff;
      n_in          = n_ff;
      target_in     = target_ff;
      single_in     = single_ff;
      q_pop         = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_slot_in   = out_slot_ff;
      out_ok_in     = out_ok_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  CMD_SCAN: begin
                     cur_in    = next_index_ff;
                     pass_in   = 1'b0;
                     n_in      = 7'd0;
                     target_in = q_cmd.target;
                     single_in = q_cmd.single;
                  end
                  CMD_RELEASE: begin
                     if (release_ok) begin
                        used_in[q_cmd.slot] = 1'b0;
                     end
                     out_valid_in = 1'b1;
                     out_slot_in  = q_cmd.slot;
                     out_ok_in    = release_ok;
                     out_last_in  = 1'b1;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     out_slot_in  = q_cmd.slot;
                     out_ok_in    = 1'b0;
                     out_last_in  = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (in_range) begin
                  cur_in = cur_ff + 7'd1;
                  if (slot_free) begin
                     used_in[cur_ff[5:0]] = 1'b1;
                     n_in         = n_ff + 7'd1;
                     out_valid_in = 1'b1;
                     out_slot_in  = cur_ff[5:0];
                     out_ok_in    = 1'b1;
                     out_last_in  = final_grant;
                     if (final_grant) begin
                        next_index_in = cur_ff + 7'd1;
                     end
                  end
               end else if (!pass_ff) begin
                  pass_in = 1'b1;
                  cur_in  = 7'd0;
               end else if (single_ff) begin
                  next_index_in = 7'd0;
               end
            end
         end
         ST_GROW: begin
            if (out_free) begin
               n_in         = n_ff + 7'd1;
               out_valid_in = 1'b1;
               out_last_in  = final_grant;
               if (can_grow) begin
                  used_in[pool_size_ff[5:0]] = 1'b1;
                  pool_size_in = pool_size_ff + 7'd1;
                  out_slot_in  = pool_size_ff[5:0];
                  out_ok_in    = 1'b1;
               end else begin
                  out_slot_in = 6'd0;
                  out_ok_in   = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         next_index_ff <= 7'd0;
         pool_size_ff  <= cap_size(RESET_POOL_SIZE);
         out_valid_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         next_index_ff <= 7'd0;
         pool_size_ff  <= cap_size(csr_wr_data);
         out_valid_ff  <= out_valid_in;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         next_index_ff <= next_index_in;
         pool_size_ff  <= pool_size_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      pass_ff     <= pass_in;
      n_ff        <= n_in;
      target_ff   <= target_in;
      single_ff   <= single_in;
      out_slot_ff <= out_slot_in;
      out_ok_ff   <= out_ok_in;
      out_last_ff <= out_last_in;
   end

`ifndef SYNTHESIS
   a_pool_cap: assert property (@(posedge clock) disable iff (reset)
      pool_size_ff <= POOL_CAPACITY)
      else $error("pool size beyond capacity");

   a_next_in_pool: assert property (@(posedge clock) disable iff (reset)
      next_index_ff <= pool_size_ff)
      else $error("next index beyond active pool");

   a_count_below_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_GROW) |-> (n_ff < target_ff))
      else $error("grant count reached target while busy");

   a_grow_from_scan: assert property (@(posedge clock) disable iff (reset || csr_wr_en)
      $rose(state_ff == ST_GROW) |-> ($past(state_ff) == ST_SCAN && $past(pass_ff)))
      else $error("growth entered without a full scan");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_slot_ff)))
      else $error("stalled result changed");
`endif

endmodule

/* hdl/next_fit_slot_allocator_unit.sv */
// Top level of the next-fit slot allocator: front end, command queue and engine.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: count, slot; tuser: action
//   rsp      out  rsp_tvalid/rsp_tready  tdata: granted_slot; tuser: granted; tlast
//   csr      in   csr_wr_en              csr_wr_data: initial_pool_size
//
// Release, rejected and unknown requests give a single result, registered in the queue, then in the output register.
// Allocations walk the active pool one slot per cycle from the next index, wrapping once,
// while the result register is free; slots still owed then grow the pool, or fail at capacity.
// Reset clears the used flags directly; they are flip-flops and need no clearing pass.
// A stalled result holds in the output register and pauses the scan; the queue keeps
// taking up to two requests meanwhile.
module next_fit_slot_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [6:0] count, [12:7] slot, [15:13] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] granted_slot, [7:6] zero
   output logic        rsp_tuser,   // [0] granted
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import nfsa_pkg::*;

   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             q_push;
   logic             q_pop;

   nfsa_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   nfsa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .status   (q_status),
      .head_cmd (head_cmd)
   );

   nfsa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* sim/tb_next_fit_slot_allocator_unit.sv */
// Self-checking testbench for the next-fit slot allocator: directed cases, then random traffic.
module tb_next_fit_slot_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import nfsa_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 2000;
   localparam int         PHASES      = 6;
   localparam int         PHASE_ITEMS = 68;

   typedef struct packed {
      logic [5:0] slot;
      logic       granted;
      logic       last;
   } slot_grant_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   // allocator shadow state
   bit         slot_used [64];
   logic [6:0] next_idx;
   logic [6:0] pool_sz;

   slot_grant_type pending_grants [$];
   int             error_count = 0;
   int             quiet_cycles = 0;
   bit             tx_idle_on = 1'b1;
   bit             rx_idle_on = 1'b1;

   next_fit_slot_allocator_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_pool(input logic [6:0] size);
      int i;
      for (i = 0; i < 64; i++) slot_used[i] = 1'b0;
      next_idx = '0;
      pool_sz  = (size > POOL_CAPACITY) ? POOL_CAPACITY : size;
   endfunction

   function automatic void push_grant(input int slot, input bit ok, input bit fin);
      slot_grant_type g;
      g.slot    = 6'(slot);
      g.granted = ok;
      g.last    = fin;
      pending_grants = {pending_grants, g};
   endfunction

   // grow by one slot if capacity allows, else report a failed grant
   function automatic void grow_or_fail(input bit fin);
      if (pool_sz < POOL_CAPACITY) begin
         slot_used[pool_sz] = 1'b1;
         push_grant(pool_sz, 1'b1, fin);
         pool_sz = pool_sz + 7'd1;
      end else begin
         push_grant(0, 1'b0, fin);
      end
   endfunction

   function automatic void model_request(input logic [1:0] act, input logic [6:0] cnt,
                                         input logic [5:0] slt);
      int i;
      int pos;
      int want;
      int got;
      int pass;
      int lo;
      int hi;
      case (act)
         ACT_ALLOC_ONE: begin
            pos = -1;
            for (i = next_idx; i < pool_sz && pos < 0; i++) if (!slot_used[i]) pos = i;
            for (i = 0; i < next_idx && pos < 0; i++) if (!slot_used[i]) pos = i;
            if (pos >= 0) begin
               slot_used[pos] = 1'b1;
               next_idx = 7'(pos + 1);
               push_grant(pos, 1'b1, 1'b1);
            end else begin
               next_idx = '0;
               grow_or_fail(1'b1);
            end
         end
         ACT_ALLOC_MANY: begin
            if (cnt == 0) begin
               push_grant(0, 1'b0, 1'b1);
            end else begin
               want = (cnt > POOL_CAPACITY) ? POOL_CAPACITY : cnt;
               got  = 0;
               for (pass = 0; pass < 2 && got < want; pass++) begin
                  lo = pass ? 0 : int'(next_idx);
                  hi = pass ? int'(next_idx) : int'(pool_sz);
                  for (i = lo; i < hi && i < 64 && got < want; i++) begin
                     if (!slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        got++;
                        push_grant(i, 1'b1, got == want);
                        if (got == want) next_idx = 7'(i + 1);
                     end
                  end
               end
               while (got < want) begin
                  grow_or_fail(got + 1 == want);
                  got++;
               end
            end
         end
         ACT_RELEASE: begin
            if (slt < pool_sz && slot_used[slt]) begin
               slot_used[slt] = 1'b0;
               push_grant(slt, 1'b1, 1'b1);
            end else begin
               push_grant(slt, 1'b0, 1'b1);
            end
         end
         default: push_grant(0, 1'b0, 1'b1);
      endcase
   endfunction

   task automatic send_request(input logic [1:0] act, input logic [6:0] cnt,
                               input logic [5:0] slt);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b000, slt, cnt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_request(act, cnt, slt);
   endtask

   task automatic drain_responses(input int settle);
      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic load_pool_size(input logic [6:0] size);
      drain_responses(20);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      clear_pool(size);
      @(posedge clock);
   endtask

   // default pool of 32 after reset
   task automatic test_reset_state();
      send_request(ACT_ALLOC_ONE, 7'd0, 6'd0);
      send_request(ACT_ALLOC_MANY, 7'd3, 6'd0);
      send_request(ACT_RELEASE, 7'd0, 6'd2);
      send_request(ACT_RELEASE, 7'd0, 6'd2);   // already free
      send_request(ACT_RELEASE, 7'd0, 6'd40);  // outside active pool
      send_request(ACT_ALLOC_MANY, 7'd0, 6'd0);
      send_request(ACT_UNUSED, 7'd127, 6'd63);
      send_request(ACT_ALLOC_ONE, 7'd127, 6'd63);
      send_request(ACT_ALLOC_MANY, 7'd127, 6'd0); // saturates, grows, then fails
      send_request(ACT_ALLOC_ONE, 7'd0, 6'd0);    // capacity exhausted
      send_request(ACT_RELEASE, 7'd0, 6'd63);
   endtask

   task automatic test_pool_extremes();
      load_pool_size(7'd0);
      send_request(ACT_ALLOC_ONE, 7'd0, 6'd0);
      send_request(ACT_ALLOC_MANY, 7'd2, 6'd0);
      send_request(ACT_RELEASE, 7'd0, 6'd5);
      load_pool_size(7'd64);
      send_request(ACT_ALLOC_MANY, 7'd64, 6'd0);
      send_request(ACT_RELEASE, 7'd0, 6'd63);
      send_request(ACT_ALLOC_ONE, 7'd0, 6'd0);
      load_pool_size(7'd127);
      send_request(ACT_ALLOC_ONE, 7'd0, 6'd0);
      load_pool_size(7'd1);
      send_request(ACT_ALLOC_ONE, 7'd0, 6'd0);
      send_request(ACT_ALLOC_ONE, 7'd0, 6'd0);
      send_request(ACT_ALLOC_MANY, 7'd5, 6'd0);
   endtask

   task automatic test_random_traffic();
      int p;
      int n;
      int i;
      int r;
      int in_use;
      int start;
      int rel_pct;
      logic [1:0] act;
      logic [6:0] cnt;
      logic [5:0] slt;
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: load_pool_size(7'd0);
            1: load_pool_size(7'd64);
            2: load_pool_size(7'd127);
            3: load_pool_size(7'd2);
            default: load_pool_size(7'($urandom_range(0, 127)));
         endcase
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            in_use = 0;
            for (i = 0; i < 64; i++) in_use += slot_used[i];
            rel_pct = (in_use * 4 > pool_sz * 3) ? 65 : 30;
            r   = $urandom_range(0, 99);
            cnt = 7'($urandom);
            slt = 6'($urandom);
            if (r < rel_pct) begin
               act = ACT_RELEASE;
               if ($urandom_range(0, 99) < 85 && in_use > 0) begin
                  start = $urandom_range(0, 63);
                  for (i = 0; i < 64; i++) begin
                     if (slot_used[(start + i) % 64]) begin
                        slt = 6'((start + i) % 64);
                        break;
                     end
                  end
               end
            end else if (r < rel_pct + (100 - rel_pct) / 3) begin
               act = ACT_ALLOC_ONE;
            end else if (r < 97) begin
               act = ACT_ALLOC_MANY;
               r   = $urandom_range(0, 99);
               if (r < 80)      cnt = 7'($urandom_range(1, 8));
               else if (r < 92) cnt = 7'($urandom_range(9, 64));
               else if (r < 96) cnt = 7'($urandom_range(65, 127));
               else             cnt = 7'd0;
            end else begin
               act = ACT_UNUSED;
            end
            send_request(act, cnt, slt);
         end
      end
   endtask

   initial begin : response_check
      int hold;
      slot_grant_type want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_grants.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response: slot %0d granted %0d last %0d",
                        $time, rsp_tdata[5:0], rsp_tuser, rsp_tlast);
            end else begin
               want = pending_grants.pop_front();
               if (rsp_tdata[5:0] !== want.slot) begin
                  error_count++;
                  $display("%0t: granted_slot expected %0d actual %0d",
                           $time, want.slot, rsp_tdata[5:0]);
               end
               if (rsp_tuser !== want.granted) begin
                  error_count++;
                  $display("%0t: granted expected %0d actual %0d",
                           $time, want.granted, rsp_tuser);
               end
               if (rsp_tlast !== want.last) begin
                  error_count++;
                  $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_tlast);
               end
            end
            hold = rx_idle_on ? $urandom_range(0, 5) : 0;
         end else if (hold > 0) begin
            hold--;
         end
         rsp_tready <= (hold == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL next_fit_slot_allocator_unit");
         $finish;
      end
   end

   initial begin
      clear_pool(RESET_POOL_SIZE);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_pool_extremes();
      test_random_traffic();
      drain_responses(150);
      if (error_count == 0) begin
         $display("PASS next_fit_slot_allocator_unit");
      end else begin
         $display("FAIL next_fit_slot_allocator_unit");
      end
      $finish;
   end

endmodule
